// File: rtl/mssw_pkg.sv
// Package for the mid/side stereo width block: beat types, register map,
// sequencer states and fixed widths. No dependencies.
package mssw_pkg;

	localparam int SAMPLE_W = 16;
	localparam int PEAK_W = 16;
	localparam int GAIN_FRAC_BITS_DEF = 14;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 4;

	typedef enum logic [1:0] {
		REG_STEREO_WIDTH = 2'd0,
		REG_CENTER_GAIN  = 2'd1,
		REG_SIDE_GAIN    = 2'd2,
		REG_PHASE_FIX    = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GAIN,
		ST_MID,
		ST_SIDE,
		ST_OUT
	} seq_state_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_in;
		logic signed [SAMPLE_W-1:0] right_in;
		logic                       block_last;
	} in_beat_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_out;
		logic signed [SAMPLE_W-1:0] right_out;
		logic [PEAK_W-1:0]          mid_peak;
		logic [PEAK_W-1:0]          side_peak;
		logic                       out_last;
	} out_beat_t;

endpackage

// File: rtl/mid_side_stereo_width.sv
// Top level of the mid/side stereo width block with its APB register file.
// Depends on mssw_pkg for beat types, register indexes and sequencer states.
//
// The input stage splits each accepted stereo pair into mid and side, then a
// sequencer runs one shared multiplier for four steps in turn (combined
// side gain, scaled mid, scaled side, output and peak update). A stalled
// output holds the last step until the output register frees. The input
// takes a new pair only while the sequencer is idle; the finished result
// waits in the output register meanwhile. Gains are unsigned fixed point
// with GAIN_FRAC_BITS fractional bits; writes above 3.0 (width) or 2.0
// (center and side gain) are clamped. Block peaks clear after a pair marked
// last.
module mid_side_stereo_width import mssw_pkg::*; #(
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_beat_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_beat_t             out_data,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int SW = SAMPLE_W;
	localparam int GF = GAIN_FRAC_BITS;
	localparam int RW = (GF + 2 > 16) ? GF + 2 : 16;
	localparam int GW = GF + 3;
	localparam int AW = (SW + 1 > RW + 1) ? SW + 1 : RW + 1;
	localparam int BW = (GW > RW) ? GW : RW;
	localparam int PW = AW + BW + 1;
	localparam int MW = SW + 4;
	localparam int MAGW = (MW > PEAK_W + 1) ? MW : PEAK_W + 1;
	localparam logic [31:0] GAIN_ONE = 32'd1 << GF;
	localparam logic [31:0] WIDTH_MAX = 32'd3 << GF;
	localparam logic [31:0] LEVEL_MAX = 32'd2 << GF;
	localparam logic [GW-1:0] G_MAX = GW'(6) << GF;

	function automatic logic [SW-1:0] sat_sample(input logic [MW:0] v);
		logic ovf;
		ovf = (v[MW:SW-1] != {(MW-SW+2){v[MW]}});
		if (ovf) begin
			return v[MW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
		end
		return v[SW-1:0];
	endfunction

	function automatic logic [PEAK_W-1:0] sat_peak(input logic signed [MW-1:0] v);
		logic signed [MW-1:0] a;
		logic [MAGW-1:0] m;
		a = v[MW-1] ? -v : v;
		m = MAGW'(a);
		return (m > MAGW'({PEAK_W{1'b1}})) ? {PEAK_W{1'b1}} : m[PEAK_W-1:0];
	endfunction

	// Register file
	logic [RW-1:0] stereo_width_q, center_gain_q, side_gain_q;
	logic          phase_fix_q;
	logic [31:0]   wr_val, sw_wr, cg_wr, sg_wr;
	logic          cfg_wr;
	reg_idx_t      cfg_idx;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);
	assign wr_val = 32'(pwdata[15:0]);
	assign sw_wr = (wr_val > WIDTH_MAX) ? WIDTH_MAX : wr_val;
	assign cg_wr = (wr_val > LEVEL_MAX) ? LEVEL_MAX : wr_val;
	assign sg_wr = cg_wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stereo_width_q <= GAIN_ONE[RW-1:0];
			center_gain_q <= GAIN_ONE[RW-1:0];
			side_gain_q <= GAIN_ONE[RW-1:0];
			phase_fix_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_STEREO_WIDTH: stereo_width_q <= sw_wr[RW-1:0];
				REG_CENTER_GAIN:  center_gain_q <= cg_wr[RW-1:0];
				REG_SIDE_GAIN:    side_gain_q <= sg_wr[RW-1:0];
				REG_PHASE_FIX:    phase_fix_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_STEREO_WIDTH: prdata = CFG_DATA_W'(stereo_width_q);
			REG_CENTER_GAIN:  prdata = CFG_DATA_W'(center_gain_q);
			REG_SIDE_GAIN:    prdata = CFG_DATA_W'(side_gain_q);
			REG_PHASE_FIX:    prdata = CFG_DATA_W'(phase_fix_q);
			default:          prdata = '0;
		endcase
	end

	// Sequencer and datapath
	seq_state_t state_q, state_d;
	logic       in_acc, out_free, out_load;
	logic       g_en, ms_en, ss_en;
	logic signed [AW-1:0] mul_a;
	logic [BW-1:0]        mul_b;
	logic signed [PW-1:0] prod, prod_sh;

	logic signed [SW:0]   sum_lr, dif_lr, mid_c, side_h, side_c, mid_mag, side_mag;
	logic                 flip;
	logic signed [AW-1:0] mid_q, side_q;
	logic                 last_q;
	logic [GW-1:0]        g_q;
	logic signed [MW-1:0] ms_q, ss_q;
	logic [MW:0]          left_sum, right_sum;
	logic [PEAK_W-1:0]    pm, ps, mid_pk_new, side_pk_new;
	logic [PEAK_W-1:0]    mid_peak_q, side_peak_q;
	logic                 out_valid_q;
	out_beat_t            out_data_q, out_d;

	assign in_acc = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_GAIN;
			ST_GAIN: state_d = ST_MID;
			ST_MID:  state_d = ST_SIDE;
			ST_SIDE: state_d = ST_OUT;
			ST_OUT:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		g_en = 1'b0;
		ms_en = 1'b0;
		ss_en = 1'b0;
		out_load = 1'b0;
		mul_a = mid_q;
		mul_b = BW'(center_gain_q);
		unique case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_GAIN: begin
				g_en = 1'b1;
				mul_a = AW'(stereo_width_q);
				mul_b = BW'(side_gain_q);
			end
			ST_MID: begin
				ms_en = 1'b1;
				mul_a = mid_q;
				mul_b = BW'(center_gain_q);
			end
			ST_SIDE: begin
				ss_en = 1'b1;
				mul_a = side_q;
				mul_b = BW'(g_q);
			end
			ST_OUT:  out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Split into mid and side; antiphase fix flips side when mid is negative
	// and side is the larger of the two.
	assign sum_lr = {in_data.left_in[SW-1], in_data.left_in}
		+ {in_data.right_in[SW-1], in_data.right_in};
	assign dif_lr = {in_data.left_in[SW-1], in_data.left_in}
		- {in_data.right_in[SW-1], in_data.right_in};
	assign mid_c = sum_lr >>> 1;
	assign side_h = dif_lr >>> 1;
	assign mid_mag = mid_c[SW] ? -mid_c : mid_c;
	assign side_mag = side_h[SW] ? -side_h : side_h;
	assign flip = phase_fix_q && mid_c[SW] && (unsigned'(side_mag) > unsigned'(mid_mag));
	assign side_c = flip ? -side_h : side_h;

	assign prod = mul_a * $signed({1'b0, mul_b});
	assign prod_sh = prod >>> GF;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mid_q <= AW'(mid_c);
			side_q <= AW'(side_c);
			last_q <= in_data.block_last;
		end
		if (g_en) g_q <= prod_sh[GW-1:0];
		if (ms_en) ms_q <= prod_sh[MW-1:0];
		if (ss_en) ss_q <= prod_sh[MW-1:0];
	end

	assign left_sum = {ms_q[MW-1], ms_q} + {ss_q[MW-1], ss_q};
	assign right_sum = {ms_q[MW-1], ms_q} - {ss_q[MW-1], ss_q};
	assign pm = sat_peak(ms_q);
	assign ps = sat_peak(ss_q);
	assign mid_pk_new = (pm > mid_peak_q) ? pm : mid_peak_q;
	assign side_pk_new = (ps > side_peak_q) ? ps : side_peak_q;

	always_comb begin
		out_d.left_out = sat_sample(left_sum);
		out_d.right_out = sat_sample(right_sum);
		out_d.mid_peak = mid_pk_new;
		out_d.side_peak = side_pk_new;
		out_d.out_last = last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_peak_q <= '0;
			side_peak_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				mid_peak_q <= last_q ? '0 : mid_pk_new;
				side_peak_q <= last_q ? '0 : side_pk_new;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) out_data_q <= out_d;
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	// A finished step always lands in the output register.
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT && out_free |=> out_valid_q)
		else $error("result step did not load the output register");

	// Peaks start over after the beat that closes a block.
	a_peak_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && last_q |=> mid_peak_q == '0 && side_peak_q == '0)
		else $error("block peaks not cleared after last beat");

	// Within a block the running peak never falls below the reported one.
	a_peak_mono: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_data_q.out_last |->
		mid_peak_q >= out_data_q.mid_peak && side_peak_q >= out_data_q.side_peak)
		else $error("running peak below reported peak");

	// Clamped gains keep the combined side gain within six.
	a_g_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SIDE |-> g_q <= G_MAX)
		else $error("combined side gain out of range");

endmodule
